/* rtl/bqebs_pkg.sv */
`default_nettype none
package bqebs_pkg;

  localparam int unsigned RMS_WINDOW_LOG2 = 6;
  localparam int unsigned CNT_W = RMS_WINDOW_LOG2;

  localparam int unsigned COEF_W = 16;
  localparam int unsigned THR_W = 31;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned IDX_W = 3;
  localparam int unsigned RMS_W = 16;

  localparam int unsigned Q_SHIFT = 12;
  localparam int unsigned ATTACK_SHIFT = 2;
  localparam int unsigned RELEASE_SHIFT = 6;

  localparam logic [IDX_W-1:0] REG_B0 = 3'd0;
  localparam logic [IDX_W-1:0] REG_B1 = 3'd1;
  localparam logic [IDX_W-1:0] REG_B2 = 3'd2;
  localparam logic [IDX_W-1:0] REG_A1 = 3'd3;
  localparam logic [IDX_W-1:0] REG_A2 = 3'd4;
  localparam logic [IDX_W-1:0] REG_THR_LOW = 3'd5;
  localparam logic [IDX_W-1:0] REG_THR_MID = 3'd6;
  localparam logic [IDX_W-1:0] REG_THR_HIGH = 3'd7;

  localparam logic signed [COEF_W-1:0] B0_RST = 16'sd275;
  localparam logic signed [COEF_W-1:0] B1_RST = 16'sd550;
  localparam logic signed [COEF_W-1:0] B2_RST = 16'sd275;
  localparam logic signed [COEF_W-1:0] A1_RST = 16'sd4682;
  localparam logic signed [COEF_W-1:0] A2_RST = -16'sd1692;
  localparam logic [THR_W-1:0] THR_LOW_RST = 31'd800;
  localparam logic [THR_W-1:0] THR_MID_RST = 31'd2400;
  localparam logic [THR_W-1:0] THR_HIGH_RST = 31'd3600;

  localparam logic [DATA_W-1:0] ROOT_BIT_START = 32'h4000_0000;

endpackage
`default_nettype wire

/* rtl/biquad_envelope_band_stats_top.sv */
`default_nettype none
// Biquad low-pass, envelope follower, band histogram and windowed RMS.
// Channels: a sample request on in_valid_i/in_ready_o, a result request on
// out_valid_o/out_ready_i, and register writes on cfg_valid_i/cfg_ready_o
// (index 0..7: b0, b1, b2, a1, a2, thr_low, thr_mid, thr_high).
// One 33x33 multiplier is shared by the five biquad taps and the squaring
// of the filtered value; a one-bit-pair-per-cycle unit takes the square root.
// The result is loaded after the MAC, sum, square and band steps, and on
// the last sample of each 64-sample window also after 16 root steps.
// in_ready_o is high only while no sample is in work; the result sits in an
// output register, so a new sample is taken while the last result waits.
// When the receiver stalls, the result and out_valid_o hold, and a finished
// item waits in its last step until the output register frees.
// Reset clears filter delays, envelope, histogram, square sum, RMS and the
// window count, and loads the register reset values. cfg_ready_o is always
// high; write registers only while the block is idle.
module biquad_envelope_band_stats_top (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   in_valid_i,
  output logic                                        in_ready_o,
  input  wire logic signed [15:0]                     raw_sample_i,
  output logic                                        out_valid_o,
  input  wire logic                                   out_ready_i,
  output logic signed [bqebs_pkg::DATA_W-1:0]         filtered_o,
  output logic [bqebs_pkg::THR_W-1:0]                 envelope_o,
  output logic [1:0]                                  band_o,
  output logic [bqebs_pkg::DATA_W-1:0]                band_count_o,
  output logic [bqebs_pkg::RMS_W-1:0]                 rms_value_o,
  output logic                                        rms_new_o,
  input  wire logic                                   cfg_valid_i,
  output logic                                        cfg_ready_o,
  input  wire logic [bqebs_pkg::IDX_W-1:0]            cfg_index_i,
  input  wire logic [bqebs_pkg::DATA_W-1:0]           cfg_data_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_SUM,
    ST_SQ,
    ST_BAND,
    ST_ROOT,
    ST_OUT
  } state_e;

  localparam int unsigned DW = bqebs_pkg::DATA_W;
  localparam int unsigned TW = bqebs_pkg::THR_W;
  localparam int unsigned CW = bqebs_pkg::COEF_W;

  state_e state_q;
  logic [2:0] tap_q;

  logic signed [CW-1:0] b0_q, b1_q, b2_q, a1_q, a2_q;
  logic [TW-1:0] thr_low_q, thr_mid_q, thr_high_q;

  logic signed [15:0] x_q;
  logic [DW-1:0] in_d1_q, in_d2_q, out_d1_q, out_d2_q;
  logic [DW-1:0] acc_q, y_q, m_q;
  logic [63:0] prod_q, sq_acc_q;
  logic [TW-1:0] env_q;
  logic [DW-1:0] hist_q [4];
  logic [bqebs_pkg::CNT_W-1:0] cnt_q;
  logic [bqebs_pkg::RMS_W-1:0] rms_q;
  logic [1:0] band_q;
  logic [DW-1:0] bcnt_q;
  logic rms_new_q;
  logic [DW-1:0] root_v_q, root_r_q, root_bit_q;

  logic out_valid_q;
  logic signed [DW-1:0] o_filtered_q;
  logic [TW-1:0] o_env_q;
  logic [1:0] o_band_q;
  logic [DW-1:0] o_bcnt_q;
  logic [bqebs_pkg::RMS_W-1:0] o_rms_q;
  logic o_rms_new_q;

  // shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_q == ST_SQ) begin
      mul_a = {1'b0, m_q};
      mul_b = {1'b0, m_q};
    end else begin
      unique case (tap_q)
        3'd0: begin
          mul_a = 33'(b0_q);
          mul_b = 33'(x_q);
        end
        3'd1: begin
          mul_a = 33'(b1_q);
          mul_b = {1'b0, in_d1_q};
        end
        3'd2: begin
          mul_a = 33'(b2_q);
          mul_b = {1'b0, in_d2_q};
        end
        3'd3: begin
          mul_a = 33'(a1_q);
          mul_b = {1'b0, out_d1_q};
        end
        3'd4: begin
          mul_a = 33'(a2_q);
          mul_b = {1'b0, out_d2_q};
        end
        default: begin
          mul_a = '0;
          mul_b = '0;
        end
      endcase
    end
  end

  assign mul_p = mul_a * mul_b;

  logic [DW-1:0] acc_sum, y_new, m_new;
  assign acc_sum = acc_q + prod_q[DW-1:0];
  assign y_new = DW'($signed(acc_sum) >>> bqebs_pkg::Q_SHIFT);
  assign m_new = y_new[DW-1] ? (DW'(0) - y_new) : y_new;

  logic [TW-1:0] mag, env_new;
  assign mag = m_q[DW-1] ? {TW{1'b1}} : m_q[TW-1:0];
  assign env_new = (mag > env_q)
    ? env_q + ((mag - env_q) >> bqebs_pkg::ATTACK_SHIFT)
    : env_q - ((env_q - mag) >> bqebs_pkg::RELEASE_SHIFT);

  logic [1:0] band_w;
  always_comb begin
    priority if (env_q < thr_low_q) band_w = 2'd0;
    else if (env_q < thr_mid_q) band_w = 2'd1;
    else if (env_q < thr_high_q) band_w = 2'd2;
    else band_w = 2'd3;
  end

  logic [DW-1:0] hist_inc;
  logic [63:0] sq_sum;
  assign hist_inc = hist_q[band_w] + DW'(1);
  assign sq_sum = sq_acc_q + prod_q;

  logic [DW-1:0] root_t, root_r_next;
  logic root_ge;
  assign root_t = root_r_q + root_bit_q;
  assign root_ge = root_v_q >= root_t;
  assign root_r_next = root_ge ? (root_r_q >> 1) + root_bit_q : root_r_q >> 1;

  logic out_free;
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      tap_q <= '0;
      b0_q <= bqebs_pkg::B0_RST;
      b1_q <= bqebs_pkg::B1_RST;
      b2_q <= bqebs_pkg::B2_RST;
      a1_q <= bqebs_pkg::A1_RST;
      a2_q <= bqebs_pkg::A2_RST;
      thr_low_q <= bqebs_pkg::THR_LOW_RST;
      thr_mid_q <= bqebs_pkg::THR_MID_RST;
      thr_high_q <= bqebs_pkg::THR_HIGH_RST;
      x_q <= '0;
      in_d1_q <= '0;
      in_d2_q <= '0;
      out_d1_q <= '0;
      out_d2_q <= '0;
      acc_q <= '0;
      y_q <= '0;
      m_q <= '0;
      prod_q <= '0;
      env_q <= '0;
      for (int i = 0; i < 4; i++) hist_q[i] <= '0;
      sq_acc_q <= '0;
      rms_q <= '0;
      cnt_q <= '0;
      band_q <= '0;
      bcnt_q <= '0;
      rms_new_q <= 1'b0;
      root_v_q <= '0;
      root_r_q <= '0;
      root_bit_q <= '0;
      out_valid_q <= 1'b0;
      o_filtered_q <= '0;
      o_env_q <= '0;
      o_band_q <= '0;
      o_bcnt_q <= '0;
      o_rms_q <= '0;
      o_rms_new_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          bqebs_pkg::REG_B0: b0_q <= cfg_data_i[CW-1:0];
          bqebs_pkg::REG_B1: b1_q <= cfg_data_i[CW-1:0];
          bqebs_pkg::REG_B2: b2_q <= cfg_data_i[CW-1:0];
          bqebs_pkg::REG_A1: a1_q <= cfg_data_i[CW-1:0];
          bqebs_pkg::REG_A2: a2_q <= cfg_data_i[CW-1:0];
          bqebs_pkg::REG_THR_LOW: thr_low_q <= cfg_data_i[TW-1:0];
          bqebs_pkg::REG_THR_MID: thr_mid_q <= cfg_data_i[TW-1:0];
          bqebs_pkg::REG_THR_HIGH: thr_high_q <= cfg_data_i[TW-1:0];
          default: ;
        endcase
      end

      if (out_valid_q && out_ready_i && (state_q != ST_OUT)) out_valid_q <= 1'b0;

      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            x_q <= raw_sample_i;
            tap_q <= '0;
            state_q <= ST_MAC;
          end
        end
        ST_MAC: begin
          prod_q <= mul_p[63:0];
          acc_q <= (tap_q == 3'd0) ? '0 : acc_sum;
          tap_q <= tap_q + 3'd1;
          if (tap_q == 3'd4) state_q <= ST_SUM;
        end
        ST_SUM: begin
          y_q <= y_new;
          m_q <= m_new;
          in_d2_q <= in_d1_q;
          in_d1_q <= DW'(x_q);
          out_d2_q <= out_d1_q;
          out_d1_q <= y_new;
          state_q <= ST_SQ;
        end
        ST_SQ: begin
          prod_q <= mul_p[63:0];
          env_q <= env_new;
          state_q <= ST_BAND;
        end
        ST_BAND: begin
          band_q <= band_w;
          hist_q[band_w] <= hist_inc;
          bcnt_q <= hist_inc;
          cnt_q <= cnt_q + bqebs_pkg::CNT_W'(1);
          if (&cnt_q) begin
            root_v_q <= sq_sum[bqebs_pkg::RMS_WINDOW_LOG2 +: DW];
            root_r_q <= '0;
            root_bit_q <= bqebs_pkg::ROOT_BIT_START;
            sq_acc_q <= '0;
            rms_new_q <= 1'b1;
            state_q <= ST_ROOT;
          end else begin
            sq_acc_q <= sq_sum;
            rms_new_q <= 1'b0;
            state_q <= ST_OUT;
          end
        end
        ST_ROOT: begin
          if (root_ge) root_v_q <= root_v_q - root_t;
          root_r_q <= root_r_next;
          root_bit_q <= root_bit_q >> 2;
          if (root_bit_q == DW'(1)) begin
            rms_q <= root_r_next[bqebs_pkg::RMS_W-1:0];
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            o_filtered_q <= y_q;
            o_env_q <= env_q;
            o_band_q <= band_q;
            o_bcnt_q <= bcnt_q;
            o_rms_q <= rms_q;
            o_rms_new_q <= rms_new_q;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign filtered_o = o_filtered_q;
  assign envelope_o = o_env_q;
  assign band_o = o_band_q;
  assign band_count_o = o_bcnt_q;
  assign rms_value_o = o_rms_q;
  assign rms_new_o = o_rms_new_q;

endmodule
`default_nettype wire

/* rtl/bqebs_checker.sv */
`default_nettype none
module bqebs_checker (
  input wire logic                               clk_i,
  input wire logic                               rst_ni,
  input wire logic                               in_valid_i,
  input wire logic                               in_ready_o,
  input wire logic                               out_valid_o,
  input wire logic                               out_ready_i,
  input wire logic signed [bqebs_pkg::DATA_W-1:0] filtered_o,
  input wire logic [bqebs_pkg::THR_W-1:0]        envelope_o,
  input wire logic [1:0]                         band_o,
  input wire logic [bqebs_pkg::DATA_W-1:0]       band_count_o,
  input wire logic [bqebs_pkg::RMS_W-1:0]        rms_value_o,
  input wire logic                               rms_new_o
);

  // a taken sample keeps the block busy
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("in_ready_o high right after a sample request");

  // a new result only appears as the block goes idle
  a_result_ends_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("result loaded while a sample is still in work");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(filtered_o)
      && $stable(envelope_o) && $stable(band_o) && $stable(band_count_o)
      && $stable(rms_value_o) && $stable(rms_new_o))
    else $error("stalled result changed");

  // the stored RMS only changes on a window's last sample
  a_rms_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) && !rms_new_o |-> rms_value_o == $past(rms_value_o)
      || $past(rms_value_o) == '0)
    else $error("rms_value_o changed without rms_new_o");

endmodule

bind biquad_envelope_band_stats_top bqebs_checker u_bqebs_checker (.*);
`default_nettype wire
